[src/dmmfd_pkg.sv]
// Shared types and constants of the multimeter serial frame decoder.
package dmmfd_pkg;

  localparam logic [7:0] ByteRestart = 8'h0a;
  localparam logic [7:0] ByteEnd     = 8'h0d;
  localparam logic [7:0] ByteNull    = 8'h00;

  localparam int unsigned FrameLen = 14;
  localparam int unsigned PosW     = $clog2(FrameLen);
  localparam logic [PosW-1:0] LastPos = PosW'(FrameLen - 1);

  // Characters that the meter shows on overflow.
  localparam logic [7:0] CharSemi  = 8'h3b;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharColon = 8'h3a;

  // Byte 7 values that place the decimal point.
  localparam logic [7:0] PointAt2 = 8'd31;
  localparam logic [7:0] PointAt3 = 8'd32;
  localparam logic [7:0] PointAt4 = 8'd34;

  localparam logic [2:0] PointNone = 3'd0;
  localparam logic [2:0] PointTwo  = 3'd2;
  localparam logic [2:0] PointThree = 3'd3;
  localparam logic [2:0] PointFour = 3'd4;

  localparam logic [2:0] PrefixNone  = 3'd0;
  localparam logic [2:0] PrefixMega  = 3'd1;
  localparam logic [2:0] PrefixKilo  = 3'd2;
  localparam logic [2:0] PrefixMilli = 3'd3;
  localparam logic [2:0] PrefixMicro = 3'd4;

  localparam logic [2:0] UnitNone   = 3'd0;
  localparam logic [2:0] UnitFarad  = 3'd1;
  localparam logic [2:0] UnitHertz  = 3'd2;
  localparam logic [2:0] UnitOhm    = 3'd3;
  localparam logic [2:0] UnitAmpere = 3'd4;
  localparam logic [2:0] UnitVolt   = 3'd5;

  localparam logic [2:0] ModeNone = 3'd0;
  localparam logic [2:0] ModeAc   = 3'd1;
  localparam logic [2:0] ModeDc   = 3'd2;
  localparam logic [2:0] ModeDu   = 3'd3;
  localparam logic [2:0] ModeDi   = 3'd4;
  localparam logic [2:0] ModeCa   = 3'd5;
  localparam logic [2:0] ModeFr   = 3'd6;
  localparam logic [2:0] ModeOh   = 3'd7;

  // Bit masks of the status bytes.
  localparam logic [7:0] Bit1 = 8'h02;
  localparam logic [7:0] Bit2 = 8'h04;
  localparam logic [7:0] Bit3 = 8'h08;
  localparam logic [7:0] Bit4 = 8'h10;
  localparam logic [7:0] Bit5 = 8'h20;
  localparam logic [7:0] Bit6 = 8'h40;

  // Frame bytes that the decoder looks at.
  typedef struct packed {
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [7:0] b4;
    logic [7:0] b5;
    logic [7:0] b7;
    logic [7:0] b8;
    logic [7:0] b10;
    logic [7:0] b11;
  } frame_t;

  typedef struct packed {
    logic close;
    logic good;
  } close_t;

  typedef struct packed {
    logic       frame_ok;
    logic [7:0] sign_char;
    logic [7:0] digit_one;
    logic [7:0] digit_two;
    logic [7:0] digit_three;
    logic [7:0] digit_four;
    logic [2:0] point_pos;
    logic [2:0] prefix_code;
    logic [2:0] unit_code;
    logic [2:0] mode_code;
    logic       over_range;
  } res_t;

endpackage

[src/dmm_serial_frame_decoder.sv]
// Top level of the multimeter serial frame decoder.
// Takes one received byte per cycle and gives one word per closed 14-byte frame (or per
// early end byte): a decoded reading when the frame is good, an all-zero word with
// frame_ok low otherwise. A byte passes through the input register and the decode logic
// into the result register. The input is stalled only while the result register holds a
// word that the downstream side is stalling; otherwise a byte is taken in every cycle.
module dmm_serial_frame_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       frame_ok_o,
  output logic [7:0] sign_char_o,
  output logic [7:0] digit_one_o,
  output logic [7:0] digit_two_o,
  output logic [7:0] digit_three_o,
  output logic [7:0] digit_four_o,
  output logic [2:0] point_pos_o,
  output logic [2:0] prefix_code_o,
  output logic [2:0] unit_code_o,
  output logic [2:0] mode_code_o,
  output logic       over_range_o
);

  logic              en;
  logic              out_valid_q;
  dmmfd_pkg::res_t   res_q, res;
  dmmfd_pkg::frame_t frame;
  dmmfd_pkg::close_t close;

  // The whole pipeline moves unless a finished word is being held back.
  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  dmmfd_collect u_collect (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .in_valid_i (in_valid_i),
    .rx_byte_i  (rx_byte_i),
    .frame_o    (frame),
    .close_o    (close)
  );

  dmmfd_decode u_decode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .commit_i (en && close.good),
    .good_i   (close.good),
    .frame_i  (frame),
    .res_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= close.close;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && close.close) begin
      res_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign frame_ok_o    = res_q.frame_ok;
  assign sign_char_o   = res_q.sign_char;
  assign digit_one_o   = res_q.digit_one;
  assign digit_two_o   = res_q.digit_two;
  assign digit_three_o = res_q.digit_three;
  assign digit_four_o  = res_q.digit_four;
  assign point_pos_o   = res_q.point_pos;
  assign prefix_code_o = res_q.prefix_code;
  assign unit_code_o   = res_q.unit_code;
  assign mode_code_o   = res_q.mode_code;
  assign over_range_o  = res_q.over_range;

  // A failed frame carries nothing but its flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !frame_ok_o |-> sign_char_o == 8'h00 && digit_four_o == 8'h00
      && point_pos_o == dmmfd_pkg::PointNone && prefix_code_o == dmmfd_pkg::PrefixNone
      && unit_code_o == dmmfd_pkg::UnitNone && mode_code_o == dmmfd_pkg::ModeNone
      && !over_range_o)
    else $error("failed frame word carries decoded fields");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_ok_o |-> point_pos_o != 3'd1 && point_pos_o <= dmmfd_pkg::PointFour
      && prefix_code_o <= dmmfd_pkg::PrefixMicro && unit_code_o <= dmmfd_pkg::UnitVolt)
    else $error("decoded code out of range");

  // A held word must back-pressure the input so that no closing byte is lost.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input accepted while result word is held");

  // The prefix, once set by a good frame, never returns to none; the unit is held alike.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && frame_ok_o && prefix_code_o != dmmfd_pkg::PrefixNone
      ##1 out_valid_o && frame_ok_o |-> prefix_code_o != dmmfd_pkg::PrefixNone)
    else $error("held prefix lost");

endmodule

[src/dmmfd_collect.sv]
// Input register, byte position counter and capture of the frame bytes.
module dmmfd_collect (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                in_valid_i,
  input  logic [7:0]          rx_byte_i,
  output dmmfd_pkg::frame_t   frame_o,
  output dmmfd_pkg::close_t   close_o
);

  logic                         vld_q;
  logic [7:0]                   byte_q;
  logic [dmmfd_pkg::PosW-1:0]   count_q, count_d;
  logic [dmmfd_pkg::PosW-1:0]   pos;
  logic                         full;
  dmmfd_pkg::frame_t            frame_q, frame_d;
  logic [7:0]                   b12_q, b12_d;

  always_comb begin
    // A restart byte always lands at position 0.
    pos  = (byte_q == dmmfd_pkg::ByteRestart) ? '0 : count_q;
    full = (pos == dmmfd_pkg::LastPos);

    close_o.close = vld_q && (full || (byte_q == dmmfd_pkg::ByteEnd));
    close_o.good  = vld_q && full && (b12_q == dmmfd_pkg::ByteNull)
                    && (byte_q == dmmfd_pkg::ByteEnd);

    frame_d = frame_q;
    b12_d   = b12_q;
    case (pos)
      4'd1:    frame_d.b1  = byte_q;
      4'd2:    frame_d.b2  = byte_q;
      4'd3:    frame_d.b3  = byte_q;
      4'd4:    frame_d.b4  = byte_q;
      4'd5:    frame_d.b5  = byte_q;
      4'd7:    frame_d.b7  = byte_q;
      4'd8:    frame_d.b8  = byte_q;
      4'd10:   frame_d.b10 = byte_q;
      4'd11:   frame_d.b11 = byte_q;
      4'd12:   b12_d       = byte_q;
      default: ;
    endcase

    count_d = close_o.close ? '0 : pos + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= 1'b0;
      count_q <= '0;
    end else if (en_i) begin
      vld_q <= in_valid_i;
      if (vld_q) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (in_valid_i) begin
        byte_q <= rx_byte_i;
      end
      if (vld_q) begin
        frame_q <= frame_d;
        b12_q   <= b12_d;
      end
    end
  end

  assign frame_o = frame_q;

endmodule

[src/dmmfd_decode.sv]
// Decoding of a closed frame and the held prefix and unit codes.
module dmmfd_decode (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               commit_i,
  input  logic               good_i,
  input  dmmfd_pkg::frame_t  frame_i,
  output dmmfd_pkg::res_t    res_o
);

  logic [2:0] held_prefix_q, held_prefix_d;
  logic [2:0] held_unit_q, held_unit_d;
  logic [2:0] point;
  logic [2:0] mode;
  logic       over;

  always_comb begin
    if (frame_i.b7 == dmmfd_pkg::PointAt2) begin
      point = dmmfd_pkg::PointTwo;
    end else if (frame_i.b7 == dmmfd_pkg::PointAt3) begin
      point = dmmfd_pkg::PointThree;
    end else if (frame_i.b7 == dmmfd_pkg::PointAt4) begin
      point = dmmfd_pkg::PointFour;
    end else begin
      point = dmmfd_pkg::PointNone;
    end

    // With no prefix or unit bit set, the last decoded value stands.
    if ((frame_i.b10 & dmmfd_pkg::Bit3) != '0) begin
      held_prefix_d = dmmfd_pkg::PrefixMega;
    end else if ((frame_i.b10 & dmmfd_pkg::Bit4) != '0) begin
      held_prefix_d = dmmfd_pkg::PrefixKilo;
    end else if ((frame_i.b10 & dmmfd_pkg::Bit5) != '0) begin
      held_prefix_d = dmmfd_pkg::PrefixMilli;
    end else if ((frame_i.b10 & dmmfd_pkg::Bit6) != '0) begin
      held_prefix_d = dmmfd_pkg::PrefixMicro;
    end else begin
      held_prefix_d = held_prefix_q;
    end

    if ((frame_i.b11 & dmmfd_pkg::Bit2) != '0) begin
      held_unit_d = dmmfd_pkg::UnitFarad;
    end else if ((frame_i.b11 & dmmfd_pkg::Bit3) != '0) begin
      held_unit_d = dmmfd_pkg::UnitHertz;
    end else if ((frame_i.b11 & dmmfd_pkg::Bit4) != '0) begin
      held_unit_d = dmmfd_pkg::UnitOhm;
    end else if ((frame_i.b11 & dmmfd_pkg::Bit5) != '0) begin
      held_unit_d = dmmfd_pkg::UnitAmpere;
    end else if ((frame_i.b11 & dmmfd_pkg::Bit6) != '0) begin
      held_unit_d = dmmfd_pkg::UnitVolt;
    end else begin
      held_unit_d = held_unit_q;
    end

    if ((frame_i.b8 & dmmfd_pkg::Bit2) != '0) begin
      mode = dmmfd_pkg::ModeAc;
    end else if ((frame_i.b8 & dmmfd_pkg::Bit3) != '0) begin
      mode = dmmfd_pkg::ModeDc;
    end else if ((frame_i.b10 & dmmfd_pkg::Bit1) != '0) begin
      mode = dmmfd_pkg::ModeDu;
    end else if ((frame_i.b10 & dmmfd_pkg::Bit2) != '0) begin
      mode = dmmfd_pkg::ModeDi;
    end else if ((frame_i.b11 & dmmfd_pkg::Bit2) != '0) begin
      mode = dmmfd_pkg::ModeCa;
    end else if ((frame_i.b11 & dmmfd_pkg::Bit3) != '0) begin
      mode = dmmfd_pkg::ModeFr;
    end else if ((frame_i.b11 & dmmfd_pkg::Bit4) != '0) begin
      mode = dmmfd_pkg::ModeOh;
    end else begin
      mode = dmmfd_pkg::ModeNone;
    end

    over = (frame_i.b2 == dmmfd_pkg::CharSemi) && (frame_i.b3 == dmmfd_pkg::CharZero)
           && (frame_i.b4 == dmmfd_pkg::CharColon) && (frame_i.b5 == dmmfd_pkg::CharSemi);

    // A bad frame yields an all-zero word apart from the flag itself.
    res_o = '0;
    if (good_i) begin
      res_o.frame_ok    = 1'b1;
      res_o.sign_char   = frame_i.b1;
      res_o.digit_one   = frame_i.b2;
      res_o.digit_two   = frame_i.b3;
      res_o.digit_three = frame_i.b4;
      res_o.digit_four  = frame_i.b5;
      res_o.point_pos   = point;
      res_o.prefix_code = held_prefix_d;
      res_o.unit_code   = held_unit_d;
      res_o.mode_code   = mode;
      res_o.over_range  = over;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_prefix_q <= dmmfd_pkg::PrefixNone;
      held_unit_q   <= dmmfd_pkg::UnitNone;
    end else if (commit_i) begin
      held_prefix_q <= held_prefix_d;
      held_unit_q   <= held_unit_d;
    end
  end

endmodule

[tb/testbench.sv]
// Self-checking testbench for the multimeter serial frame decoder.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [7:0] frame_buf_t [dmmfd_pkg::FrameLen];

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] rx_byte_i = 8'h00;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic       frame_ok_o;
  logic [7:0] sign_char_o;
  logic [7:0] digit_one_o;
  logic [7:0] digit_two_o;
  logic [7:0] digit_three_o;
  logic [7:0] digit_four_o;
  logic [2:0] point_pos_o;
  logic [2:0] prefix_code_o;
  logic [2:0] unit_code_o;
  logic [2:0] mode_code_o;
  logic       over_range_o;

  dmm_serial_frame_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .frame_ok_o    (frame_ok_o),
    .sign_char_o   (sign_char_o),
    .digit_one_o   (digit_one_o),
    .digit_two_o   (digit_two_o),
    .digit_three_o (digit_three_o),
    .digit_four_o  (digit_four_o),
    .point_pos_o   (point_pos_o),
    .prefix_code_o (prefix_code_o),
    .unit_code_o   (unit_code_o),
    .mode_code_o   (mode_code_o),
    .over_range_o  (over_range_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Decoder state as the testbench sees it.
  int unsigned       frame_pos = 0;
  frame_buf_t        frame_buf = '{default: 8'h00};
  logic [2:0]        last_prefix = dmmfd_pkg::PrefixNone;
  logic [2:0]        last_unit = dmmfd_pkg::UnitNone;
  dmmfd_pkg::res_t   pending_readings[$];

  int unsigned mismatch_count = 0;
  int unsigned bytes_sent = 0;
  // Odds of an idle burst per byte sent or per output cycle, one in idle_odds; zero means no idling.
  int unsigned idle_odds = 0;
  int unsigned out_burst = 0;

  // Works out the word, if any, that the byte just taken will produce.
  task automatic decode_rx_byte(input logic [7:0] b);
    dmmfd_pkg::res_t w;
    logic [7:0]      st8, st10, st11;
    bit              closed;
    w = '0;
    closed = 1'b0;
    if (b == dmmfd_pkg::ByteRestart) frame_pos = 0;
    frame_buf[frame_pos] = b;
    frame_pos++;
    if (frame_pos == dmmfd_pkg::FrameLen) begin
      frame_pos = 0;
      closed = 1'b1;
      if (frame_buf[12] == dmmfd_pkg::ByteNull && frame_buf[13] == dmmfd_pkg::ByteEnd) begin
        st8  = frame_buf[8];
        st10 = frame_buf[10];
        st11 = frame_buf[11];
        if      (st10 & dmmfd_pkg::Bit3) last_prefix = dmmfd_pkg::PrefixMega;
        else if (st10 & dmmfd_pkg::Bit4) last_prefix = dmmfd_pkg::PrefixKilo;
        else if (st10 & dmmfd_pkg::Bit5) last_prefix = dmmfd_pkg::PrefixMilli;
        else if (st10 & dmmfd_pkg::Bit6) last_prefix = dmmfd_pkg::PrefixMicro;
        if      (st11 & dmmfd_pkg::Bit2) last_unit = dmmfd_pkg::UnitFarad;
        else if (st11 & dmmfd_pkg::Bit3) last_unit = dmmfd_pkg::UnitHertz;
        else if (st11 & dmmfd_pkg::Bit4) last_unit = dmmfd_pkg::UnitOhm;
        else if (st11 & dmmfd_pkg::Bit5) last_unit = dmmfd_pkg::UnitAmpere;
        else if (st11 & dmmfd_pkg::Bit6) last_unit = dmmfd_pkg::UnitVolt;
        w.frame_ok    = 1'b1;
        w.sign_char   = frame_buf[1];
        w.digit_one   = frame_buf[2];
        w.digit_two   = frame_buf[3];
        w.digit_three = frame_buf[4];
        w.digit_four  = frame_buf[5];
        case (frame_buf[7])
          dmmfd_pkg::PointAt2: w.point_pos = dmmfd_pkg::PointTwo;
          dmmfd_pkg::PointAt3: w.point_pos = dmmfd_pkg::PointThree;
          dmmfd_pkg::PointAt4: w.point_pos = dmmfd_pkg::PointFour;
          default:             w.point_pos = dmmfd_pkg::PointNone;
        endcase
        w.prefix_code = last_prefix;
        w.unit_code   = last_unit;
        if      (st8 & dmmfd_pkg::Bit2)  w.mode_code = dmmfd_pkg::ModeAc;
        else if (st8 & dmmfd_pkg::Bit3)  w.mode_code = dmmfd_pkg::ModeDc;
        else if (st10 & dmmfd_pkg::Bit1) w.mode_code = dmmfd_pkg::ModeDu;
        else if (st10 & dmmfd_pkg::Bit2) w.mode_code = dmmfd_pkg::ModeDi;
        else if (st11 & dmmfd_pkg::Bit2) w.mode_code = dmmfd_pkg::ModeCa;
        else if (st11 & dmmfd_pkg::Bit3) w.mode_code = dmmfd_pkg::ModeFr;
        else if (st11 & dmmfd_pkg::Bit4) w.mode_code = dmmfd_pkg::ModeOh;
        else                             w.mode_code = dmmfd_pkg::ModeNone;
        w.over_range = (frame_buf[2] == dmmfd_pkg::CharSemi &&
                        frame_buf[3] == dmmfd_pkg::CharZero &&
                        frame_buf[4] == dmmfd_pkg::CharColon &&
                        frame_buf[5] == dmmfd_pkg::CharSemi);
      end
    end else if (b == dmmfd_pkg::ByteEnd) begin
      frame_pos = 0;
      closed = 1'b1;
    end
    if (closed) pending_readings.push_back(w);
  endtask

  task automatic send_byte(input logic [7:0] b);
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    decode_rx_byte(b);
    bytes_sent++;
  endtask

  task automatic send_frame(input frame_buf_t f);
    for (int i = 0; i < dmmfd_pkg::FrameLen; i++) send_byte(f[i]);
  endtask

  // Any byte except the two framing bytes, so that a frame body stays intact.
  function automatic logic [7:0] body_byte();
    logic [7:0] b;
    b = 8'($urandom);
    while (b == dmmfd_pkg::ByteRestart || b == dmmfd_pkg::ByteEnd) b = 8'($urandom);
    return b;
  endfunction

  function automatic logic [7:0] status_byte();
    logic [7:0] b;
    case ($urandom_range(0, 3))
      0:       b = 8'h00;
      1:       b = 8'h01 << $urandom_range(1, 6);
      2:       b = (8'h01 << $urandom_range(1, 6)) | (8'h01 << $urandom_range(1, 6));
      default: b = 8'($urandom);
    endcase
    if (b == dmmfd_pkg::ByteRestart || b == dmmfd_pkg::ByteEnd) b = body_byte();
    return b;
  endfunction

  function automatic logic [7:0] display_char();
    case ($urandom_range(0, 3))
      0:       return body_byte();
      1:       return dmmfd_pkg::CharSemi;
      default: return 8'h30 + 8'($urandom_range(0, 9));
    endcase
  endfunction

  function automatic frame_buf_t random_frame();
    frame_buf_t f;
    int unsigned p;
    f[0] = dmmfd_pkg::ByteRestart;
    f[1] = ($urandom_range(0, 2) == 0) ? body_byte() : ($urandom_range(0, 1) ? 8'h2b : 8'h2d);
    if ($urandom_range(0, 5) == 0) begin
      f[2] = dmmfd_pkg::CharSemi;
      f[3] = dmmfd_pkg::CharZero;
      f[4] = dmmfd_pkg::CharColon;
      f[5] = dmmfd_pkg::CharSemi;
    end else begin
      for (int i = 2; i <= 5; i++) f[i] = display_char();
    end
    f[6] = body_byte();
    case ($urandom_range(0, 3))
      0:       f[7] = dmmfd_pkg::PointAt2;
      1:       f[7] = dmmfd_pkg::PointAt3;
      2:       f[7] = dmmfd_pkg::PointAt4;
      default: f[7] = body_byte();
    endcase
    f[8]  = status_byte();
    f[9]  = body_byte();
    f[10] = status_byte();
    f[11] = status_byte();
    f[12] = dmmfd_pkg::ByteNull;
    f[13] = dmmfd_pkg::ByteEnd;
    // Now and then one byte is spoilt, which may end the frame early or restart it.
    if ($urandom_range(0, 7) == 0) begin
      p = $urandom_range(1, dmmfd_pkg::FrameLen - 1);
      f[p] = 8'($urandom);
    end
    return f;
  endfunction

  task automatic report_field(input string name, input logic [7:0] got,
                              input logic [7:0] want);
    if (got !== want) begin
      $display("%0t: %s got %h, expected %h", $realtime, name, got, want);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin : check_words
    dmmfd_pkg::res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_readings.size() == 0) begin
        report_field("word with none pending, out_valid", 8'(out_valid_o), 8'h00);
      end else begin
        want = pending_readings.pop_front();
        report_field("frame_ok", 8'(frame_ok_o), 8'(want.frame_ok));
        report_field("sign_char", sign_char_o, want.sign_char);
        report_field("digit_one", digit_one_o, want.digit_one);
        report_field("digit_two", digit_two_o, want.digit_two);
        report_field("digit_three", digit_three_o, want.digit_three);
        report_field("digit_four", digit_four_o, want.digit_four);
        report_field("point_pos", 8'(point_pos_o), 8'(want.point_pos));
        report_field("prefix_code", 8'(prefix_code_o), 8'(want.prefix_code));
        report_field("unit_code", 8'(unit_code_o), 8'(want.unit_code));
        report_field("mode_code", 8'(mode_code_o), 8'(want.mode_code));
        report_field("over_range", 8'(over_range_o), 8'(want.over_range));
      end
    end
  end

  always @(posedge clk_i) begin
    if (idle_odds == 0) begin
      out_stall_i <= 1'b0;
      out_burst   <= 0;
    end else if (out_burst != 0) begin
      out_stall_i <= 1'b1;
      out_burst   <= out_burst - 1;
    end else if ($urandom_range(1, idle_odds) == 1) begin
      out_stall_i <= 1'b1;
      out_burst   <= $urandom_range(0, 9);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Overflow reading with extreme bytes around it, decimal point at four, micro volts AC.
  task automatic test_good_frame();
    frame_buf_t f;
    f = '{dmmfd_pkg::ByteRestart, 8'hff, dmmfd_pkg::CharSemi, dmmfd_pkg::CharZero,
          dmmfd_pkg::CharColon, dmmfd_pkg::CharSemi, 8'h00, dmmfd_pkg::PointAt4,
          dmmfd_pkg::Bit2, 8'hff, dmmfd_pkg::Bit6, dmmfd_pkg::Bit6,
          dmmfd_pkg::ByteNull, dmmfd_pkg::ByteEnd};
    send_frame(f);
  endtask

  // An end byte as the very first byte of a frame.
  task automatic test_early_end();
    send_byte(dmmfd_pkg::ByteEnd);
  endtask

  // A restart byte in the middle of a frame, then an early end.
  task automatic test_restart();
    send_byte(dmmfd_pkg::ByteRestart);
    send_byte(8'h7f);
    send_byte(dmmfd_pkg::ByteRestart);
    send_byte(8'h80);
    send_byte(dmmfd_pkg::ByteEnd);
  endtask

  task automatic test_random_traffic();
    int unsigned stop_at;
    int unsigned chunk_end;
    stop_at = bytes_sent + 420;
    while (bytes_sent < stop_at) begin
      case ($urandom_range(0, 2))
        0:       idle_odds = 0;
        1:       idle_odds = 3;
        default: idle_odds = 10;
      endcase
      chunk_end = bytes_sent + 60;
      while (bytes_sent < chunk_end) begin
        if ($urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(1, 20)) send_byte(8'($urandom));
        end else begin
          send_frame(random_frame());
        end
      end
    end
  endtask

  // Back-to-back frames at full rate on both sides.
  task automatic test_steady_stream();
    idle_odds = 0;
    repeat (4) send_frame(random_frame());
  endtask

  initial begin
    idle_odds = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_good_frame();
    test_early_end();
    test_restart();
    test_random_traffic();
    test_steady_stream();
    in_valid_i <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
